@@ hdl/azd_pkg.sv @@
// Shared types and constants for the air mass pipeline.
// Depends on nothing; every other file in hdl uses it by scoped names.
`timescale 1ns / 1ps
package azd_pkg;

   localparam int FRAC_BITS_DEF    = 16;
   localparam int COSINE_STEPS_DEF = 16;

   localparam int Q         = 30;
   localparam int ANGLE_W   = 20;
   localparam int AIRMASS_W = 20;

   // internal widths, all Q30
   localparam int X_W     = 31;   // clamped angle, below 1.52 * 2^30
   localparam int SQ_W    = 32;   // angle squared, below 2.31 * 2^30
   localparam int COS_W   = 32;   // signed cosine, within [-1, 1]
   localparam int CZ_W    = 31;   // floored cosine, within [1/64, 1]
   localparam int REM_W   = 31;   // divider remainder, below the divisor
   localparam int SEC_W   = 37;   // secant, up to 64
   localparam int S_W     = 36;   // secant minus one
   localparam int T_W     = 28;   // C*s + B
   localparam int T2_W    = 34;   // s*(C*s + B)
   localparam int INNER_W = 31;   // A - s*(C*s + B), clamped at zero
   localparam int AM_W    = 37;   // air mass before rounding

   localparam longint unsigned ONE       = 64'd1 << Q;
   localparam longint unsigned PI_Q30    = 64'd3373259426;
   localparam longint unsigned ZMAX      = (64'd87 * PI_Q30 + 64'd90) / 64'd180;
   localparam longint unsigned COS_FLOOR = ONE / 64'd64;
   localparam longint unsigned COEF_A    = (64'd9981833 * ONE + 64'd5000000) / 64'd10000000;
   localparam longint unsigned COEF_B    = (64'd2875 * ONE + 64'd500000) / 64'd1000000;
   localparam longint unsigned COEF_C    = (64'd8083 * ONE + 64'd5000000) / 64'd10000000;
   localparam longint unsigned OUT_MAX   = (64'd1 << AIRMASS_W) - 64'd1;

   // 2^60 shifted down past the quotient bits that are always zero
   localparam longint unsigned REM_INIT  = 64'd1 << (2 * Q - SEC_W);

   typedef logic [X_W-1:0]          x_type;
   typedef logic [SQ_W-1:0]         sq_type;
   typedef logic signed [COS_W-1:0] cos_type;
   typedef logic [CZ_W-1:0]         cz_type;
   typedef logic [SEC_W-1:0]        sec_type;

endpackage

@@ hdl/azd_front.sv @@
// Front end: angle magnitude, clamp at 87 degrees, then the square.
// Two register stages. Depends on azd_pkg.
`timescale 1ns / 1ps
module azd_front #(
   parameter int FRAC_BITS = azd_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic signed [azd_pkg::ANGLE_W-1:0]   angle,
   output logic                                 out_valid,
   output azd_pkg::sq_type                      x2
);
   localparam int SHIFT = azd_pkg::Q - FRAC_BITS;
   localparam int WIDE  = azd_pkg::ANGLE_W + SHIFT;

   logic [azd_pkg::ANGLE_W-1:0] mag;
   logic [WIDE-1:0]             x_wide;
   azd_pkg::x_type              x_in, x_ff;
   azd_pkg::sq_type             x2_in, x2_ff;
   logic [2*azd_pkg::X_W-1:0]   sq;
   logic                        v1_ff, v2_ff;

   always_comb begin
      mag    = angle[azd_pkg::ANGLE_W-1] ? (azd_pkg::ANGLE_W'(0) - angle) : angle;
      x_wide = WIDE'(mag) << SHIFT;
      if (64'(x_wide) > azd_pkg::ZMAX) begin
         x_in = azd_pkg::X_W'(azd_pkg::ZMAX);
      end else begin
         x_in = x_wide[azd_pkg::X_W-1:0];
      end
      sq    = (2*azd_pkg::X_W)'(x_ff) * (2*azd_pkg::X_W)'(x_ff);
      x2_in = sq[azd_pkg::Q +: azd_pkg::SQ_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff  <= x_in;
         x2_ff <= x2_in;
      end
   end

   assign out_valid = v2_ff;
   assign x2        = x2_ff;
endmodule

@@ hdl/azd_cos_step.sv @@
// One Horner step of the cosine series: c = 1 - trunc(x2*c / (d * 2^30)).
// Two register stages; the divide by d is an exact reciprocal multiply. Depends on azd_pkg.
`timescale 1ns / 1ps
module azd_cos_step #(
   parameter int K = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  azd_pkg::sq_type  x2_i,
   input  azd_pkg::cos_type c_i,
   output logic             out_valid,
   output azd_pkg::sq_type  x2_o,
   output azd_pkg::cos_type c_o
);
   localparam int N   = azd_pkg::SQ_W;
   localparam int D   = (2*K - 1) * (2*K);
   localparam int L   = $clog2(D);
   localparam longint unsigned M = ((64'd1 << (N + L)) + 64'(D) - 64'd1) / 64'(D);
   localparam int MW  = N + 1;
   localparam int PW  = N + MW;
   localparam int CW  = azd_pkg::COS_W + 2;

   logic [azd_pkg::COS_W-2:0]            cabs;
   logic [azd_pkg::SQ_W+azd_pkg::COS_W-2:0] p;
   logic [N-1:0]                         n_in, n_ff;
   logic                                 neg_ff;
   azd_pkg::sq_type                      x2a_ff, x2b_ff;
   logic [PW-1:0]                        prod;
   logic [N-1:0]                         q;
   logic signed [CW-1:0]                 cn;
   azd_pkg::cos_type                     c_in, c_ff;
   logic                                 v1_ff, v2_ff;

   always_comb begin
      cabs = c_i[azd_pkg::COS_W-1] ? (azd_pkg::COS_W-1)'(-c_i)
                                   : c_i[azd_pkg::COS_W-2:0];
      p    = ($bits(p))'(x2_i) * ($bits(p))'(cabs);
      n_in = p[azd_pkg::Q +: N];

      prod = PW'(n_ff) * PW'(M[MW-1:0]);
      q    = N'(prod >> (N + L));
      if (neg_ff) begin
         cn = CW'(azd_pkg::ONE) + $signed({2'b00, q});
      end else begin
         cn = CW'(azd_pkg::ONE) - $signed({2'b00, q});
      end
      // hold within [-1, 1]
      if (cn > $signed(CW'(azd_pkg::ONE))) begin
         c_in = azd_pkg::COS_W'(azd_pkg::ONE);
      end else if (cn < -$signed(CW'(azd_pkg::ONE))) begin
         c_in = -azd_pkg::COS_W'(azd_pkg::ONE);
      end else begin
         c_in = cn[azd_pkg::COS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff   <= n_in;
         neg_ff <= c_i[azd_pkg::COS_W-1];
         x2a_ff <= x2_i;
         x2b_ff <= x2a_ff;
         c_ff   <= c_in;
      end
   end

   assign out_valid = v2_ff;
   assign x2_o      = x2b_ff;
   assign c_o       = c_ff;
endmodule

@@ hdl/azd_recip.sv @@
// Secant as floor(2^60 / cos): floor the cosine, then a restoring divider,
// one quotient bit per register stage after the floor stage. Depends on azd_pkg.
`timescale 1ns / 1ps
module azd_recip (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  azd_pkg::cos_type c_i,
   output logic             out_valid,
   output azd_pkg::sec_type sec
);
   localparam int NB = azd_pkg::SEC_W;

   azd_pkg::cz_type         cz_in;
   azd_pkg::cz_type         cz_ff  [0:NB];
   logic [azd_pkg::REM_W-1:0] rem_ff [0:NB];
   azd_pkg::sec_type        quo_ff [0:NB];
   logic [azd_pkg::REM_W-1:0] rem_in [1:NB];
   azd_pkg::sec_type        quo_in [1:NB];
   logic [NB:0]             v_ff;
   logic [azd_pkg::REM_W:0] rs;

   always_comb begin
      if (c_i < $signed(azd_pkg::COS_W'(azd_pkg::COS_FLOOR))) begin
         cz_in = azd_pkg::CZ_W'(azd_pkg::COS_FLOOR);
      end else begin
         cz_in = c_i[azd_pkg::CZ_W-1:0];
      end
      rs = '0;
      for (int i = 0; i < NB; i++) begin
         rs = {rem_ff[i], 1'b0};
         if (rs >= (azd_pkg::REM_W+1)'(cz_ff[i])) begin
            rem_in[i+1] = azd_pkg::REM_W'(rs - (azd_pkg::REM_W+1)'(cz_ff[i]));
            quo_in[i+1] = {quo_ff[i][NB-2:0], 1'b1};
         end else begin
            rem_in[i+1] = rs[azd_pkg::REM_W-1:0];
            quo_in[i+1] = {quo_ff[i][NB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NB-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cz_ff[0]  <= cz_in;
         rem_ff[0] <= azd_pkg::REM_W'(azd_pkg::REM_INIT);
         quo_ff[0] <= '0;
         for (int i = 1; i <= NB; i++) begin
            cz_ff[i]  <= cz_ff[i-1];
            rem_ff[i] <= rem_in[i];
            quo_ff[i] <= quo_in[i];
         end
      end
   end

   assign out_valid = v_ff[NB];
   assign sec       = quo_ff[NB];
endmodule

@@ hdl/azd_poly.sv @@
// Cubic in s = sec - 1 by Horner, then round and saturate to the output.
// Five register stages, the last one is the output register. Depends on azd_pkg.
`timescale 1ns / 1ps
module azd_poly #(
   parameter int FRAC_BITS = azd_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  azd_pkg::sec_type                sec,
   output logic                            out_valid,
   output logic [azd_pkg::AIRMASS_W-1:0]   air_mass
);
   localparam int RSH  = azd_pkg::Q - FRAC_BITS;
   localparam int RW   = azd_pkg::AM_W + 1;
   localparam int P1W  = azd_pkg::S_W + 20;
   localparam int P2W  = azd_pkg::S_W + azd_pkg::T_W;
   localparam int P3W  = azd_pkg::S_W + azd_pkg::INNER_W;

   logic [azd_pkg::S_W-1:0]     s_in, s0_ff, s1_ff, s2_ff;
   logic [P1W-1:0]              p1;
   logic [azd_pkg::T_W-1:0]     t_in, t_ff;
   logic [P2W-1:0]              p2;
   logic [azd_pkg::T2_W-1:0]    t2;
   logic [azd_pkg::INNER_W-1:0] inner_in, inner_ff;
   logic [P3W-1:0]              p3;
   logic [azd_pkg::AM_W-1:0]    am_in, am_ff;
   logic [RW-1:0]               res;
   logic [azd_pkg::AIRMASS_W-1:0] out_in, out_ff;
   logic [4:0]                  v_ff;

   always_comb begin
      if (sec > azd_pkg::SEC_W'(azd_pkg::ONE)) begin
         s_in = azd_pkg::S_W'(sec - azd_pkg::SEC_W'(azd_pkg::ONE));
      end else begin
         s_in = '0;
      end

      p1   = P1W'(s0_ff) * P1W'(azd_pkg::COEF_C);
      t_in = azd_pkg::T_W'(p1 >> azd_pkg::Q) + azd_pkg::T_W'(azd_pkg::COEF_B);

      p2 = P2W'(s1_ff) * P2W'(t_ff);
      t2 = azd_pkg::T2_W'(p2 >> azd_pkg::Q);
      // clamp the inner difference at zero
      if (64'(t2) >= azd_pkg::COEF_A) begin
         inner_in = '0;
      end else begin
         inner_in = azd_pkg::INNER_W'(azd_pkg::COEF_A) - azd_pkg::INNER_W'(t2);
      end

      p3    = P3W'(s2_ff) * P3W'(inner_ff);
      am_in = azd_pkg::AM_W'(azd_pkg::ONE) + azd_pkg::AM_W'(p3 >> azd_pkg::Q);

      res = (RW'(am_ff) + (RW'(1) << (RSH - 1))) >> RSH;
      if (64'(res) > azd_pkg::OUT_MAX) begin
         out_in = azd_pkg::AIRMASS_W'(azd_pkg::OUT_MAX);
      end else begin
         out_in = res[azd_pkg::AIRMASS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff    <= s_in;
         s1_ff    <= s0_ff;
         t_ff     <= t_in;
         s2_ff    <= s1_ff;
         inner_ff <= inner_in;
         am_ff    <= am_in;
         out_ff   <= out_in;
      end
   end

   assign out_valid = v_ff[4];
   assign air_mass  = out_ff;
endmodule

@@ hdl/airmass_from_zenith_distance.sv @@
// Relative air mass from zenith distance: top level of the pipeline.
// Depends on azd_pkg, azd_front, azd_cos_step, azd_recip and azd_poly.
//
//   channel   ports                        beat
//   request   req_valid/req_ready          req_zenith_angle, signed Q.FRAC_BITS radians
//   response  rsp_valid/rsp_ready          rsp_air_mass, unsigned Q.FRAC_BITS, saturating
//
// One beat in per cycle, one beat out per cycle at full flow.
// Stages: two front stages, two per cosine step, one floor stage plus one per
// secant quotient bit, five polynomial stages.
// Every stage advances together whenever the output register is empty or being taken.
// Reset clears the valid bits only; the data registers are not reset.
`timescale 1ns / 1ps
module airmass_from_zenith_distance #(
   parameter int FRAC_BITS    = azd_pkg::FRAC_BITS_DEF,
   parameter int COSINE_STEPS = azd_pkg::COSINE_STEPS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [azd_pkg::ANGLE_W-1:0]  req_zenith_angle,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [azd_pkg::AIRMASS_W-1:0]       rsp_air_mass
);
   logic             en;
   logic             v_chain  [0:COSINE_STEPS];
   azd_pkg::sq_type  x2_chain [0:COSINE_STEPS];
   azd_pkg::cos_type c_chain  [0:COSINE_STEPS];
   logic             rv;
   azd_pkg::sec_type sec;

   // advance when the output register is free or its beat is taken
   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;

   azd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .angle     (req_zenith_angle),
      .out_valid (v_chain[0]),
      .x2        (x2_chain[0])
   );

   assign c_chain[0] = azd_pkg::COS_W'(azd_pkg::ONE);

   for (genvar i = 0; i < COSINE_STEPS; i++) begin : g_cos
      azd_cos_step #(.K(COSINE_STEPS - i)) u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (v_chain[i]),
         .x2_i      (x2_chain[i]),
         .c_i       (c_chain[i]),
         .out_valid (v_chain[i+1]),
         .x2_o      (x2_chain[i+1]),
         .c_o       (c_chain[i+1])
      );
   end

   azd_recip u_recip (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v_chain[COSINE_STEPS]),
      .c_i       (c_chain[COSINE_STEPS]),
      .out_valid (rv),
      .sec       (sec)
   );

   azd_poly #(.FRAC_BITS(FRAC_BITS)) u_poly (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rv),
      .sec       (sec),
      .out_valid (rsp_valid),
      .air_mass  (rsp_air_mass)
   );
endmodule

@@ tb/tb_airmass_from_zenith_distance.sv @@
// Testbench for airmass_from_zenith_distance: drives angles, predicts the air mass
// in fixed point and compares every response beat. Depends on azd_pkg and the block.
`timescale 1ns / 1ps
module tb_airmass_from_zenith_distance;

   localparam int FRAC = azd_pkg::FRAC_BITS_DEF;
   localparam int STEPS = azd_pkg::COSINE_STEPS_DEF;
   localparam int LATENCY = 2 * STEPS + 45;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [azd_pkg::ANGLE_W-1:0] req_zenith_angle = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [azd_pkg::AIRMASS_W-1:0] rsp_air_mass;

   logic [azd_pkg::AIRMASS_W-1:0] airmass_expected[$];
   int mismatches = 0;
   int hold_off = 0;
   int rsp_beats = 0;
   int rsp_seen = 0;
   int rsp_gap = 0;
   bit allow_rsp_idle = 1'b1;

   airmass_from_zenith_distance u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_zenith_angle(req_zenith_angle),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_air_mass(rsp_air_mass)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #200ms;
      $display("tb_airmass_from_zenith_distance: errors");
      $finish;
   end

   // floor(a*b / 2^30), exact for the widths used here
   function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
      return (a >> azd_pkg::Q) * b + (((a & (azd_pkg::ONE - 1)) * b) >> azd_pkg::Q);
   endfunction

   function automatic logic [azd_pkg::AIRMASS_W-1:0] airmass_of(
      logic signed [azd_pkg::ANGLE_W-1:0] z);
      longint unsigned mag, x, x2, cz, sec, s, t, inner, am, res;
      longint c, den;
      mag = z < 0 ? longint'(-longint'(z)) : longint'(z);
      x = mag << (azd_pkg::Q - FRAC);
      if (x > azd_pkg::ZMAX) x = azd_pkg::ZMAX;
      x2 = (x * x) >> azd_pkg::Q;
      c = longint'(azd_pkg::ONE);
      for (int k = STEPS; k >= 1; k--) begin
         den = longint'(2 * k - 1) * longint'(2 * k) * longint'(azd_pkg::ONE);
         c = longint'(azd_pkg::ONE) - (longint'(x2) * c) / den;
         if (c > longint'(azd_pkg::ONE)) c = longint'(azd_pkg::ONE);
         if (c < -longint'(azd_pkg::ONE)) c = -longint'(azd_pkg::ONE);
      end
      if (c < longint'(azd_pkg::COS_FLOOR)) c = longint'(azd_pkg::COS_FLOOR);
      cz = longint'(c);
      sec = (64'd1 << (2 * azd_pkg::Q)) / cz;
      s = sec > azd_pkg::ONE ? sec - azd_pkg::ONE : 0;
      t = q30_mul(s, q30_mul(s, azd_pkg::COEF_C) + azd_pkg::COEF_B);
      inner = t >= azd_pkg::COEF_A ? 0 : azd_pkg::COEF_A - t;
      am = azd_pkg::ONE + q30_mul(s, inner);
      res = (am + (64'd1 << (azd_pkg::Q - FRAC - 1))) >> (azd_pkg::Q - FRAC);
      if (res > azd_pkg::OUT_MAX) res = azd_pkg::OUT_MAX;
      return res[azd_pkg::AIRMASS_W-1:0];
   endfunction

   // receiver: a fresh wait for every beat while allow_rsp_idle is set, unless a long hold-off is running
   always @(negedge clock) begin
      if (rsp_beats != rsp_seen) begin
         rsp_seen = rsp_beats;
         rsp_gap = allow_rsp_idle ? int'($urandom_range(0, 11)) : 0;
      end
      if (hold_off > 0) begin
         hold_off = hold_off - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap = rsp_gap - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_beats++;
         if (airmass_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat: air_mass %0d", rsp_air_mass);
         end else begin
            logic [azd_pkg::AIRMASS_W-1:0] want;
            want = airmass_expected.pop_front();
            if (want !== rsp_air_mass) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("air_mass mismatch: expected %0d, got %0d", want, rsp_air_mass);
            end
         end
      end
   end

   // valid stays high after the beat; the next call drops or replaces it
   task automatic send_angle(logic signed [azd_pkg::ANGLE_W-1:0] z, int max_gap);
      int gap;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_zenith_angle <= z;
      do @(posedge clock); while (!req_ready);
      airmass_expected.push_back(airmass_of(z));
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (airmass_expected.size() != 0);
   endtask

   task automatic test_extremes();
      logic signed [azd_pkg::ANGLE_W-1:0] list[$];
      list = '{20'sd0, 20'sd1, -20'sd1, 20'sd524287, 20'sh80000, 20'sd65536,
               -20'sd65536, 20'sd99528, 20'sd99529, 20'sd99530, -20'sd99529,
               20'sd102943, 20'sd51472, 20'sd34315, 20'sd91000, 20'sd95000,
               20'sd131072, 20'sh55555, 20'shAAAAA};
      foreach (list[i]) send_angle(list[i], 2);
   endtask

   task automatic test_random(int count);
      logic signed [azd_pkg::ANGLE_W-1:0] z;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 3))
            0: z = azd_pkg::ANGLE_W'($urandom_range(0, 20'hFFFFF));
            1: z = azd_pkg::ANGLE_W'($urandom_range(0, 99600));
            2: z = -$signed({1'b0, 19'($urandom_range(0, 99600))});
            default: z = azd_pkg::ANGLE_W'($urandom_range(90000, 100000));
         endcase
         send_angle(z, ($urandom_range(0, 3) == 0) ? 0 : 11);
      end
   endtask

   task automatic test_backpressure();
      hold_off = 300;
      for (int i = 0; i < 120; i++)
         send_angle(azd_pkg::ANGLE_W'($urandom_range(0, 20'hFFFFF)), 0);
      drain();
   endtask

   task automatic test_full_rate();
      allow_rsp_idle = 1'b0;
      for (int i = 0; i < 150; i++)
         send_angle(azd_pkg::ANGLE_W'($urandom_range(0, 20'hFFFFF)), 0);
      drain();
      allow_rsp_idle = 1'b1;
   endtask

   initial begin
      int waited;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extremes();
      drain();
      test_backpressure();
      test_random(500);
      test_full_rate();
      test_random(260);
      req_valid <= 1'b0;
      waited = 0;
      while (airmass_expected.size() != 0 && waited < 100000) begin
         @(negedge clock);
         waited++;
      end
      repeat (LATENCY + 20) @(negedge clock);
      if (mismatches == 0 && airmass_expected.size() == 0)
         $display("tb_airmass_from_zenith_distance: clean");
      else
         $display("tb_airmass_from_zenith_distance: errors");
      $finish;
   end
endmodule

@@ sim.f @@
hdl/azd_pkg.sv
hdl/azd_front.sv
hdl/azd_cos_step.sv
hdl/azd_recip.sv
hdl/azd_poly.sv
hdl/airmass_from_zenith_distance.sv
tb/tb_airmass_from_zenith_distance.sv
